@@ src/ptm_pkg.sv @@
package ptm_pkg;

   // Default geometry
   localparam int NUM_PAGES_DEF        = 16;
   localparam int PAGE_OFFSET_BITS_DEF = 8;
   localparam int WORD_BITS_DEF        = 16;

   // Field widths of the channels
   localparam int OP_BITS     = 2;
   localparam int TASK_BITS   = 8;
   localparam int ADDR_BITS   = 16;
   localparam int DATA_BITS   = 16;
   localparam int LPAGE_BITS  = 8;
   localparam int PHYS_BITS   = 4;
   localparam int STATUS_BITS = 2;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FAULT     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [TASK_BITS-1:0]  task_id;
      logic [ADDR_BITS-1:0]  address;
      logic [DATA_BITS-1:0]  write_value;
      logic [LPAGE_BITS-1:0] logical_page;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]   read_value;
      logic [PHYS_BITS-1:0]   physical_page;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } cmd_type;

endpackage

@@ src/ptm_ram.sv @@
module ptm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or registered read, one port
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/ptm_ctl.sv @@
module ptm_ctl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptm_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       can_take;
   logic       take;

   // Output register frees up when empty or drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_take = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign take     = req_valid && can_take;

   assign req_stall    = !can_take;
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load_req = take;
   assign cmd.exec     = (state_ff == S_LOOK);
   assign cmd.load_rsp = (state_ff == S_DONE) && out_free;

   // Sequence: register request, look up and access, deliver
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = take ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until its transfer
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/ptm_dp.sv @@
module ptm_dp #(
   parameter int NUM_PAGES        = ptm_pkg::NUM_PAGES_DEF,
   parameter int PAGE_OFFSET_BITS = ptm_pkg::PAGE_OFFSET_BITS_DEF,
   parameter int WORD_BITS        = ptm_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ptm_pkg::cmd_type cmd,
   input  ptm_pkg::req_type req_data,
   output ptm_pkg::rsp_type rsp_data
);

   localparam int PAGE_BITS   = $clog2(NUM_PAGES);
   localparam int STORE_DEPTH = NUM_PAGES << PAGE_OFFSET_BITS;
   localparam int STORE_ABITS = $clog2(STORE_DEPTH);
   localparam logic [PAGE_BITS:0] PAGE_END = (PAGE_BITS+1)'(NUM_PAGES);

   ptm_pkg::req_type req_ff;
   ptm_pkg::rsp_type rsp_ff;

   // Page table and allocator state
   logic [ptm_pkg::TASK_BITS-1:0]  owner_ff [NUM_PAGES];
   logic [ptm_pkg::LPAGE_BITS-1:0] lpage_ff [NUM_PAGES];
   logic [PAGE_BITS-1:0]           ppage_ff [NUM_PAGES];
   logic [NUM_PAGES-1:0]           used_ff;
   logic [PAGE_BITS-1:0]           hint_ff;
   logic [PAGE_BITS-1:0]           hint_in;

   // Lookup to delivery stage
   logic [ptm_pkg::STATUS_BITS-1:0] pend_status_ff;
   logic [ptm_pkg::STATUS_BITS-1:0] pend_status_in;
   logic [ptm_pkg::PHYS_BITS-1:0]   pend_phys_ff;
   logic [ptm_pkg::PHYS_BITS-1:0]   pend_phys_in;
   logic                            pend_rd_ff;
   logic                            pend_rd_in;

   logic                            bad_req;
   logic [ptm_pkg::ADDR_BITS-1:0]   addr_lpage;
   logic [PAGE_OFFSET_BITS-1:0]     offset;
   logic                            hit_found;
   logic [PAGE_BITS-1:0]            hit_idx;
   logic                            slot_found;
   logic [PAGE_BITS-1:0]            slot_idx;
   logic                            clear_found;
   logic [PAGE_BITS-1:0]            clear_idx;
   logic [PAGE_BITS-1:0]            alloc_page;
   logic                            page_ok;
   logic [PAGE_BITS:0]              page_next;
   logic                            do_alloc;
   logic [PAGE_BITS-1:0]            xlat_page;
   logic                            ram_en;
   logic                            ram_we;
   logic [STORE_ABITS-1:0]          ram_addr;
   logic [WORD_BITS-1:0]            ram_q;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
   end

   assign bad_req = (req_ff.task_id == '0) ||
                    !((req_ff.operation == ptm_pkg::OP_READ) ||
                      (req_ff.operation == ptm_pkg::OP_WRITE) ||
                      (req_ff.operation == ptm_pkg::OP_ALLOC));
   assign addr_lpage = req_ff.address >> PAGE_OFFSET_BITS;
   assign offset     = req_ff.address[PAGE_OFFSET_BITS-1:0];

   // Compare all entries in parallel, first match wins
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
         if ((owner_ff[i] != '0) && (owner_ff[i] == req_ff.task_id) &&
             (ptm_pkg::ADDR_BITS'(lpage_ff[i]) == addr_lpage)) begin
            hit_found = 1'b1;
            hit_idx   = PAGE_BITS'(i);
         end
      end
   end

   // First free table entry and first clear page
   always_comb begin
      slot_found  = 1'b0;
      slot_idx    = '0;
      clear_found = 1'b0;
      clear_idx   = '0;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
         if (owner_ff[i] == '0) begin
            slot_found = 1'b1;
            slot_idx   = PAGE_BITS'(i);
         end
         if (!used_ff[i]) begin
            clear_found = 1'b1;
            clear_idx   = PAGE_BITS'(i);
         end
      end
   end

   // Pick the page from the hint, or search when the hint is zero
   assign alloc_page = (hint_ff != '0) ? hint_ff : clear_idx;
   assign page_ok    = (hint_ff != '0) ? !used_ff[hint_ff] : clear_found;
   assign page_next  = {1'b0, alloc_page} + 1'b1;
   assign xlat_page  = ppage_ff[hit_idx];

   // Decide the outcome and drive the store
   always_comb begin
      pend_status_in = ptm_pkg::ST_FAULT;
      pend_phys_in   = '0;
      pend_rd_in     = 1'b0;
      do_alloc       = 1'b0;
      ram_en         = 1'b0;
      ram_we         = 1'b0;
      hint_in        = hint_ff;
      if (!bad_req) begin
         if (req_ff.operation == ptm_pkg::OP_ALLOC) begin
            if (page_ok && slot_found) begin
               pend_status_in = ptm_pkg::ST_OK;
               pend_phys_in   = ptm_pkg::PHYS_BITS'(alloc_page);
               do_alloc       = cmd.exec;
               if ((page_next < PAGE_END) && !used_ff[page_next[PAGE_BITS-1:0]]) begin
                  hint_in = page_next[PAGE_BITS-1:0];
               end else begin
                  hint_in = '0;
               end
            end else begin
               pend_status_in = ptm_pkg::ST_EXHAUSTED;
            end
         end else if (hit_found) begin
            pend_status_in = ptm_pkg::ST_OK;
            pend_phys_in   = ptm_pkg::PHYS_BITS'(xlat_page);
            pend_rd_in     = (req_ff.operation == ptm_pkg::OP_READ);
            ram_en         = cmd.exec;
            ram_we         = (req_ff.operation == ptm_pkg::OP_WRITE);
         end
      end
   end

   assign ram_addr = {xlat_page, offset};

   // Control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         hint_ff <= '0;
         for (int i = 0; i < NUM_PAGES; i++) owner_ff[i] <= '0;
      end else if (do_alloc) begin
         used_ff[alloc_page] <= 1'b1;
         owner_ff[slot_idx]  <= req_ff.task_id;
         hint_ff             <= hint_in;
      end
   end

   // Binding payload of a new entry
   always_ff @(posedge clock) begin
      if (do_alloc) begin
         lpage_ff[slot_idx] <= req_ff.logical_page;
         ppage_ff[slot_idx] <= alloc_page;
      end
   end

   // Advance the outcome to the delivery stage
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= pend_status_in;
         pend_phys_ff   <= pend_phys_in;
         pend_rd_ff     <= pend_rd_in;
      end
   end

   ptm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (WORD_BITS'(req_ff.write_value)),
      .rdata (ram_q)
   );

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.read_value    <= pend_rd_ff ? ptm_pkg::DATA_BITS'(ram_q) : '0;
         rsp_ff.physical_page <= pend_phys_ff;
         rsp_ff.status        <= pend_status_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ src/paged_task_memory_with_allocator.sv @@
// Each request passes through a lookup state that also drives the word store,
// then a delivery state that loads the output register from the registered read;
// while one is in flight, the next is taken only in the delivery state, once the output register is free.
// A waiting result lets one more request in; the one after it stalls until transfer.
// Reset clears the control state, the page table owners, the used-page map and
// the free-page hint; the word store is not cleared and reads undefined until written.
module paged_task_memory_with_allocator #(
   parameter int NUM_PAGES        = ptm_pkg::NUM_PAGES_DEF,
   parameter int PAGE_OFFSET_BITS = ptm_pkg::PAGE_OFFSET_BITS_DEF,
   parameter int WORD_BITS        = ptm_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptm_pkg::rsp_type rsp_data
);

   ptm_pkg::cmd_type cmd;

   ptm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ptm_dp #(
      .NUM_PAGES        (NUM_PAGES),
      .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
      .WORD_BITS        (WORD_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ dv/paged_task_memory_with_allocator_test.sv @@
`timescale 1ns / 100ps

module paged_task_memory_with_allocator_test;
   import ptm_pkg::*;

   localparam int NUM_PAGES        = NUM_PAGES_DEF;
   localparam int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF;
   localparam int STORE_DEPTH      = NUM_PAGES << PAGE_OFFSET_BITS;

   // Operation code that the block does not define
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 7;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int SETTLE_CYCLES  = 10;

   // A task together with a logical word address
   typedef struct {
      bit [TASK_BITS-1:0] owner;
      bit [ADDR_BITS-1:0] address;
   } access_type;

   // Page table, allocator and word store as the block should hold them
   class paged_memory_predictor;
      bit [DATA_BITS-1:0]  word_mem [STORE_DEPTH];
      bit                  word_written [STORE_DEPTH];
      bit                  page_used [NUM_PAGES];
      bit [TASK_BITS-1:0]  entry_task [NUM_PAGES];
      bit [LPAGE_BITS-1:0] entry_lpage [NUM_PAGES];
      bit [PHYS_BITS-1:0]  entry_phys [NUM_PAGES];
      int                  free_hint = 0;
      rsp_type             expected_results [$];
      access_type          bound_pages [$];
      access_type          written_words [$];
      int                  mismatches = 0;

      // First entry owned by the task that maps the logical page
      function int find_entry(bit [TASK_BITS-1:0] owner, bit [LPAGE_BITS-1:0] lpage);
         for (int i = 0; i < NUM_PAGES; i++) begin
            if (entry_task[i] != 0 && entry_task[i] == owner && entry_lpage[i] == lpage)
               return i;
         end
         return NUM_PAGES;
      endfunction

      // A read is safe unless it translates to a word never stored
      function bit read_is_defined(bit [TASK_BITS-1:0] owner, bit [ADDR_BITS-1:0] address);
         int e;
         if (owner == 0)
            return 1'b1;
         e = find_entry(owner, address[ADDR_BITS-1:PAGE_OFFSET_BITS]);
         if (e >= NUM_PAGES)
            return 1'b1;
         return word_written[{entry_phys[e], address[PAGE_OFFSET_BITS-1:0]}];
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Update the state for an accepted request and queue its result
      function void note_request(req_type item);
         rsp_type    want;
         int         page;
         int         slot;
         int         e;
         int         widx;
         access_type acc;
         want = '0;
         acc.owner = item.task_id;
         acc.address = item.address;
         if (item.task_id == 0 || item.operation == OP_UNUSED) begin
            want.status = ST_FAULT;
         end else if (item.operation == OP_ALLOC) begin
            page = free_hint;
            if (page == 0) begin
               page = NUM_PAGES;
               for (int i = NUM_PAGES - 1; i >= 0; i--)
                  if (!page_used[i]) page = i;
            end
            slot = NUM_PAGES;
            for (int i = NUM_PAGES - 1; i >= 0; i--)
               if (entry_task[i] == 0) slot = i;
            if (page >= NUM_PAGES || slot >= NUM_PAGES) begin
               want.status = ST_EXHAUSTED;
            end else if (page_used[page]) begin
               want.status = ST_EXHAUSTED;
            end else begin
               page_used[page] = 1'b1;
               entry_task[slot] = item.task_id;
               entry_lpage[slot] = item.logical_page;
               entry_phys[slot] = PHYS_BITS'(page);
               free_hint = page + 1;
               if (free_hint >= NUM_PAGES)
                  free_hint = 0;
               else if (page_used[free_hint])
                  free_hint = 0;
               want.physical_page = PHYS_BITS'(page);
               want.status = ST_OK;
               acc.address = '0;
               acc.address[ADDR_BITS-1:PAGE_OFFSET_BITS] = item.logical_page;
               bound_pages.push_back(acc);
            end
         end else begin
            e = find_entry(item.task_id, item.address[ADDR_BITS-1:PAGE_OFFSET_BITS]);
            if (e >= NUM_PAGES) begin
               want.status = ST_FAULT;
            end else begin
               widx = int'({entry_phys[e], item.address[PAGE_OFFSET_BITS-1:0]});
               want.physical_page = entry_phys[e];
               want.status = ST_OK;
               if (item.operation == OP_WRITE) begin
                  word_mem[widx] = item.write_value;
                  if (!word_written[widx])
                     written_words.push_back(acc);
                  word_written[widx] = 1'b1;
               end else begin
                  want.read_value = word_mem[widx];
               end
            end
         end
         expected_results.push_back(want);
      endfunction

      // Compare a result transfer with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            mismatches++;
         end
         if (got.physical_page !== want.physical_page) begin
            $error("physical_page: expected %h, got %h", want.physical_page, got.physical_page);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %h, got %h", want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   paged_memory_predictor model = new();
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic holdoff_active = 1'b0;
   event begin_holdoff;

   paged_task_memory_with_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Hold the result channel for a long stretch on request
   initial forever begin
      @(begin_holdoff);
      holdoff_active <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holdoff_active <= 1'b0;
   end

   // Stall the result channel at random and check each result transfer
   always @(posedge clock) begin
      if (holdoff_active)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall)
         model.check_response(rsp_data);
   end

   function automatic req_type make_request(logic [OP_BITS-1:0] op,
                                            logic [TASK_BITS-1:0] owner,
                                            logic [ADDR_BITS-1:0] address,
                                            logic [DATA_BITS-1:0] value,
                                            logic [LPAGE_BITS-1:0] lpage);
      req_type item;
      item.operation = op;
      item.task_id = owner;
      item.address = address;
      item.write_value = value;
      item.logical_page = lpage;
      return item;
   endfunction

   // Mostly accesses through live mappings, with allocations and noise mixed in
   function automatic req_type next_random_request();
      req_type    item;
      access_type pick;
      int         roll;
      item.operation = OP_READ;
      item.task_id = TASK_BITS'($urandom_range(255, 1));
      item.address = ADDR_BITS'($urandom);
      item.write_value = DATA_BITS'($urandom);
      item.logical_page = LPAGE_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 6) begin
         item.operation = OP_ALLOC;
      end else if (roll < 40 && model.bound_pages.size() > 0) begin
         pick = model.bound_pages[$urandom_range(model.bound_pages.size() - 1)];
         item.operation = OP_WRITE;
         item.task_id = pick.owner;
         item.address[ADDR_BITS-1:PAGE_OFFSET_BITS] = pick.address[ADDR_BITS-1:PAGE_OFFSET_BITS];
      end else if (roll < 75 && model.written_words.size() > 0) begin
         pick = model.written_words[$urandom_range(model.written_words.size() - 1)];
         item.operation = OP_READ;
         item.task_id = pick.owner;
         item.address = pick.address;
      end else if (roll < 85 && model.bound_pages.size() > 0) begin
         pick = model.bound_pages[$urandom_range(model.bound_pages.size() - 1)];
         item.operation = $urandom_range(1) ? OP_WRITE : OP_READ;
         item.task_id = pick.owner;
      end else begin
         item.operation = OP_BITS'($urandom_range(3));
         if ($urandom_range(3) == 0)
            item.task_id = '0;
         else
            item.task_id = TASK_BITS'($urandom);
      end
      // Turn a read of a never-stored word into a write
      if (item.operation == OP_READ && !model.read_is_defined(item.task_id, item.address))
         item.operation = OP_WRITE;
      return item;
   endfunction

   // Offer one request, idling first at random, and note it once transferred
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.note_request(item);
   endtask

   // Drop valid and wait until every expected result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++)
         send_request(next_random_request());
   endtask

   initial begin
      send_idle_pct = 20;
      stall_pct <= 61;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reserved task, unused code and unmapped access all fault
      send_request(make_request(OP_READ, 8'd0, 16'h0000, 16'h0000, 8'd0));
      send_request(make_request(OP_WRITE, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(make_request(OP_ALLOC, 8'd0, 16'h0000, 16'h0000, 8'h01));
      send_request(make_request(OP_UNUSED, 8'd5, 16'h1234, 16'h5678, 8'h02));
      send_request(make_request(OP_READ, 8'd1, 16'h0000, 16'h0000, 8'd0));
      // Bind pages at the field extremes, then store and fetch
      send_request(make_request(OP_ALLOC, 8'd1, 16'h0000, 16'h0000, 8'h00));
      send_request(make_request(OP_ALLOC, 8'hFF, 16'h0000, 16'h0000, 8'hFF));
      send_request(make_request(OP_WRITE, 8'd1, 16'h0000, 16'hFFFF, 8'd0));
      send_request(make_request(OP_WRITE, 8'd1, 16'h00FF, 16'h0000, 8'd0));
      send_request(make_request(OP_WRITE, 8'hFF, 16'hFFFF, 16'hA5A5, 8'd0));
      send_request(make_request(OP_WRITE, 8'hFF, 16'hFF00, 16'h5A5A, 8'd0));
      send_request(make_request(OP_READ, 8'd1, 16'h0000, 16'h0000, 8'd0));
      send_request(make_request(OP_READ, 8'd1, 16'h00FF, 16'h0000, 8'd0));
      send_request(make_request(OP_READ, 8'hFF, 16'hFFFF, 16'h0000, 8'd0));
      send_request(make_request(OP_READ, 8'hFF, 16'hFF00, 16'h0000, 8'd0));
      // Unmapped page of a live task, and another task on a mapped page
      send_request(make_request(OP_WRITE, 8'd1, 16'h0100, 16'h1111, 8'd0));
      send_request(make_request(OP_READ, 8'd2, 16'h0000, 16'h0000, 8'd0));
      // A second binding of the same page leaves the first one in force
      send_request(make_request(OP_ALLOC, 8'd1, 16'h0000, 16'h0000, 8'h00));
      send_request(make_request(OP_WRITE, 8'd1, 16'h0005, 16'h00C3, 8'd0));
      send_request(make_request(OP_READ, 8'd1, 16'h0005, 16'h0000, 8'd0));

      // Sender idles lightly, receiver heavily
      send_random(90);
      wait_for_results();
      send_random(90);
      wait_for_results();

      // Sender idles heavily, receiver lightly
      send_idle_pct = 61;
      stall_pct <= 20;
      send_random(180);
      wait_for_results();

      // Full rate, with one long receiver hold-off to back up the input
      send_idle_pct = 0;
      stall_pct <= 0;
      send_random(30);
      -> begin_holdoff;
      send_random(160);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (model.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
